>>> sv/kseq_pkg.sv
`timescale 1ns / 1ps
// kseq_pkg: shared types and constants of the key state event queue
package kseq_pkg;

  localparam int KEY_CODES_DEF   = 512;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int KEY_W    = 9;
  localparam int ACTION_W = 2;
  localparam int KIND_W   = 2;
  localparam int FILL_W   = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_KEY_EVENT  = 2'd0,
    ACT_FRAME_POLL = 2'd1,
    ACT_POP        = 2'd2,
    ACT_QUERY      = 2'd3
  } action_e;

  // key event kinds, code 3 is unused and ignored
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPEAT  = 2'd2;

  typedef struct packed {
    action_e            action;
    logic [KEY_W-1:0]   scan_code;
    logic [KIND_W-1:0]  key_action;
    logic               in_range;
  } item_t;

  typedef struct packed {
    logic is_down;
    logic was_pressed;
  } map_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]  popped_key;
    logic              popped_valid;
    logic [FILL_W-1:0] fill;
  } queue_rsp_t;

endpackage

>>> sv/kseq_ram.sv
`timescale 1ns / 1ps
// kseq_ram: generic single-clock ram, one write port, one registered read port
module kseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/kseq_key_map.sv
`timescale 1ns / 1ps
// kseq_key_map: current and previous key bitmaps in one ram, epoch tagged
module kseq_key_map #(
  parameter int KEY_CODES = kseq_pkg::KEY_CODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  kseq_pkg::item_t    item_i,
  output logic               ready_o,
  output kseq_pkg::map_rsp_t rsp_o
);

  localparam int AW = $clog2(KEY_CODES);
  localparam int TW = AW + 1;
  localparam int DW = TW + 2;
  localparam logic [AW-1:0] LAST = AW'(KEY_CODES - 1);

  // entry: {current bit, previous bit, epoch tag}
  logic [TW-1:0] epoch_q, epoch_d;
  logic [AW-1:0] scrub_q, scrub_d;
  logic [AW-1:0] clr_ptr_q, clr_ptr_d;
  logic          clr_q, clr_d;

  logic                          ex_q;
  kseq_pkg::action_e             ex_act_q;
  logic [kseq_pkg::KIND_W-1:0]   ex_kind_q;
  logic                          ex_range_q;
  logic [AW-1:0]                 ex_addr_q;

  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;

  logic          cur_s, prev_s, fresh, eff_prev, new_cur, kind_ok;
  logic [TW-1:0] tag_s;

  assign rd_addr = (item_i.action == kseq_pkg::ACT_FRAME_POLL) ? scrub_q
                                                               : AW'(item_i.scan_code);

  kseq_ram #(
    .WIDTH (DW),
    .DEPTH (KEY_CODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wa),
    .wdata_i (wd),
    .re_i    (acc_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign cur_s  = rd_data[DW-1];
  assign prev_s = rd_data[DW-2];
  assign tag_s  = rd_data[TW-1:0];
  // an entry from an older epoch has seen a poll since: previous equals current
  assign fresh    = (tag_s == epoch_q);
  assign eff_prev = fresh ? prev_s : cur_s;
  assign kind_ok  = (ex_kind_q == kseq_pkg::KIND_RELEASE) ||
                    (ex_kind_q == kseq_pkg::KIND_PRESS) ||
                    (ex_kind_q == kseq_pkg::KIND_REPEAT);

  always_comb begin
    case (ex_kind_q)
      kseq_pkg::KIND_RELEASE: new_cur = 1'b0;
      kseq_pkg::KIND_PRESS:   new_cur = 1'b1;
      default:                new_cur = cur_s;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = ex_addr_q;
    wd = {new_cur, eff_prev, epoch_q};
    if (clr_q) begin
      we = 1'b1;
      wa = clr_ptr_q;
      wd = '0;
    end else if (ex_q) begin
      unique case (ex_act_q)
        kseq_pkg::ACT_KEY_EVENT: we = ex_range_q && kind_ok;
        kseq_pkg::ACT_FRAME_POLL: begin
          we = 1'b1;
          wd = {cur_s, eff_prev, epoch_q};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_comb begin
    epoch_d   = epoch_q;
    scrub_d   = scrub_q;
    clr_d     = clr_q;
    clr_ptr_d = clr_ptr_q;
    if (acc_i && (item_i.action == kseq_pkg::ACT_FRAME_POLL)) begin
      epoch_d = epoch_q + 1'b1;
    end
    // one entry refreshed per poll keeps every tag younger than the tag range
    if (ex_q && (ex_act_q == kseq_pkg::ACT_FRAME_POLL)) begin
      scrub_d = (scrub_q == LAST) ? '0 : scrub_q + 1'b1;
    end
    if (clr_q) begin
      clr_ptr_d = clr_ptr_q + 1'b1;
      if (clr_ptr_q == LAST) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q   <= '0;
      scrub_q   <= '0;
      clr_q     <= 1'b1;
      clr_ptr_q <= '0;
      ex_q      <= 1'b0;
    end else begin
      epoch_q   <= epoch_d;
      scrub_q   <= scrub_d;
      clr_q     <= clr_d;
      clr_ptr_q <= clr_ptr_d;
      ex_q      <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      ex_act_q   <= item_i.action;
      ex_kind_q  <= item_i.key_action;
      ex_range_q <= item_i.in_range;
      ex_addr_q  <= rd_addr;
    end
  end

  assign ready_o = !clr_q;

  assign rsp_o.is_down     = ex_q && (ex_act_q == kseq_pkg::ACT_QUERY) && ex_range_q && cur_s;
  assign rsp_o.was_pressed = ex_q && (ex_act_q == kseq_pkg::ACT_QUERY) && ex_range_q &&
                             cur_s && !eff_prev;

  a_no_item_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !acc_i)
    else $error("item accepted during clearing pass");

endmodule

>>> sv/kseq_queue.sv
`timescale 1ns / 1ps
// kseq_queue: key-down fifo as a circular buffer in ram
module kseq_queue #(
  parameter int QUEUE_DEPTH = kseq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  kseq_pkg::item_t      item_i,
  output kseq_pkg::queue_rsp_t rsp_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] head_q, head_d;
  logic          pop_q;

  logic          full, empty, push, pop, queues;
  logic [PW:0]   tail_sum;
  logic [PW-1:0] tail;
  logic [kseq_pkg::KEY_W-1:0] rd_data;

  assign full   = (count_q == CW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);
  assign queues = item_i.in_range &&
                  ((item_i.key_action == kseq_pkg::KIND_PRESS) ||
                   (item_i.key_action == kseq_pkg::KIND_REPEAT));
  assign push   = acc_i && (item_i.action == kseq_pkg::ACT_KEY_EVENT) && queues && !full;
  assign pop    = acc_i && (item_i.action == kseq_pkg::ACT_POP) && !empty;

  // head plus count stays below twice the depth while not full
  assign tail_sum = {1'b0, head_q} + (PW+1)'(count_q);
  assign tail     = (tail_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                    PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);

  kseq_ram #(
    .WIDTH (kseq_pkg::KEY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (tail),
    .wdata_i (item_i.scan_code),
    .re_i    (pop),
    .raddr_i (head_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    if (acc_i && (item_i.action == kseq_pkg::ACT_FRAME_POLL)) begin
      count_d = '0;
    end else if (push) begin
      count_d = count_q + 1'b1;
    end else if (pop) begin
      count_d = count_q - 1'b1;
      head_d  = (head_q == LAST) ? '0 : head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      pop_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      pop_q   <= pop;
    end
  end

  assign rsp_o.popped_key   = pop_q ? rd_data : '0;
  assign rsp_o.popped_valid = pop_q;
  assign rsp_o.fill         = kseq_pkg::FILL_W'(count_q);

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("fifo count above depth");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_q |-> ($past(count_q) != '0) && (count_q == $past(count_q) - 1'b1))
    else $error("pop from empty fifo or bad count");

endmodule

>>> sv/key_state_event_queue_unit.sv
`timescale 1ns / 1ps
// key_state_event_queue_unit: keyboard state tracker with a key-down fifo
//
// input channel: in_valid_i / in_stall_o carry one item (action, key code, key
// event kind); output channel: out_valid_o / out_stall_i carry one result per
// item. an item moves at a clock edge where valid is high and stall is low.
// key state lives in one ram of KEY_CODES entries {current, previous, epoch tag};
// a frame poll bumps the epoch instead of copying the bitmap, and refreshes one
// entry so no tag can wrap around to look current. the fifo is a circular buffer
// in a second ram of QUEUE_DEPTH entries.
// out_valid_o rises at the edge after the accepting edge.
// a new item is not taken until the last one leaves exec, set by the read-then-write of the
// state ram (read at accept, modify and write back in the next cycle).
// reset: a clearing pass over all KEY_CODES entries zeroes the state ram; in_stall_o
// stays high until it ends. the fifo count and pointers clear at once.
// when the receiver stalls, the result waits in the output register; one more
// item is accepted only once that register is taken.
module key_state_event_queue_unit #(
  parameter int KEY_CODES   = kseq_pkg::KEY_CODES_DEF,
  parameter int QUEUE_DEPTH = kseq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [kseq_pkg::ACTION_W-1:0]  action_i,
  input  logic [kseq_pkg::KEY_W-1:0]     scan_code_i,
  input  logic [kseq_pkg::KIND_W-1:0]    key_action_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [kseq_pkg::KEY_W-1:0]     popped_key_o,
  output logic                           popped_valid_o,
  output logic                           key_is_down_o,
  output logic                           key_was_pressed_o,
  output logic [kseq_pkg::FILL_W-1:0]    queue_fill_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;

  logic                        acc;
  logic                        map_ready;
  logic [31:0]                 code_ext;
  kseq_pkg::item_t             item;
  kseq_pkg::map_rsp_t          map_rsp;
  kseq_pkg::queue_rsp_t        q_rsp;

  // output register
  logic                        out_valid_q;
  logic [kseq_pkg::KEY_W-1:0]  popped_key_q;
  logic                        popped_valid_q;
  logic                        key_is_down_q;
  logic                        key_was_pressed_q;
  logic [kseq_pkg::FILL_W-1:0] queue_fill_q;

  // key codes at or above KEY_CODES are ignored by events and queries
  assign code_ext = {{(32-kseq_pkg::KEY_W){1'b0}}, scan_code_i};

  assign item.action     = kseq_pkg::action_e'(action_i);
  assign item.scan_code  = scan_code_i;
  assign item.key_action = key_action_i;
  assign item.in_range   = (code_ext < 32'(KEY_CODES));

  // take an item only with the sequencer free, the clearing pass done and the output slot free or leaving
  assign in_stall_o = !((state_q == ST_IDLE) && map_ready &&
                        (!out_valid_q || !out_stall_i));
  assign acc        = in_valid_i && !in_stall_o;

  kseq_key_map #(
    .KEY_CODES (KEY_CODES)
  ) u_key_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .item_i  (item),
    .ready_o (map_ready),
    .rsp_o   (map_rsp)
  );

  kseq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .item_i (item),
    .rsp_o  (q_rsp)
  );

  // sequencer: accept and release a taken result in idle, finish the item and load the result in exec
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      out_valid_q       <= 1'b0;
      popped_key_q      <= '0;
      popped_valid_q    <= 1'b0;
      key_is_down_q     <= 1'b0;
      key_was_pressed_q <= 1'b0;
      queue_fill_q      <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (acc) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q           <= ST_IDLE;
          out_valid_q       <= 1'b1;
          popped_key_q      <= q_rsp.popped_key;
          popped_valid_q    <= q_rsp.popped_valid;
          key_is_down_q     <= map_rsp.is_down;
          key_was_pressed_q <= map_rsp.was_pressed;
          queue_fill_q      <= q_rsp.fill;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign popped_key_o      = popped_key_q;
  assign popped_valid_o    = popped_valid_q;
  assign key_is_down_o     = key_is_down_q;
  assign key_was_pressed_o = key_was_pressed_q;
  assign queue_fill_o      = queue_fill_q;

  a_exec_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> !out_valid_q)
    else $error("result would overwrite a pending result");

  a_exec_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("item not finished after one exec cycle");

endmodule
